// ===== hdl/pscl_pkg.sv =====
package pscl_pkg;

  // Fixed field widths of the stream beats.
  localparam int unsigned ADDR_HALF_W = 64;
  localparam int unsigned IN_DATA_W   = 2 * ADDR_HALF_W;
  localparam int unsigned IN_USER_W   = 3;
  localparam int unsigned LIMIT_W     = 16;
  localparam int unsigned ACTIVE_W    = 16;
  localparam int unsigned REJ_W       = 32;
  localparam int unsigned OUT_DATA_W  = ACTIVE_W + REJ_W;
  localparam int unsigned STATUS_W    = 3;

  // The upper half of the low word for an IPv4-mapped IPv6 address.
  localparam logic [31:0] MAPPED_PREFIX = 32'h0000_FFFF;

  // Command codes. The unused code behaves as a query.
  localparam logic [1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;

  // Result status codes.
  localparam logic [2:0] STS_GRANTED    = 3'd0;
  localparam logic [2:0] STS_UNTRACKED  = 3'd1;
  localparam logic [2:0] STS_OVER_LIMIT = 3'd2;
  localparam logic [2:0] STS_TABLE_FULL = 3'd3;
  localparam logic [2:0] STS_RELEASED   = 3'd4;
  localparam logic [2:0] STS_REL_IGNORE = 3'd5;
  localparam logic [2:0] STS_QUERY      = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_en;
    logic load;
    logic scan_en;
    logic commit;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/pscl_ctrl.sv =====
module pscl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  input  pscl_pkg::sts_t sts_i,
  output pscl_pkg::ctl_t ctl_o
);
  import pscl_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    ctl_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ctl_o.clear_en = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl_o.scan_en = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // Hold the decision until the output register can take the result.
        if (sts_i.out_free) begin
          ctl_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/pscl_dpath.sv =====
module pscl_dpath #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pscl_pkg::LIMIT_W-1:0]      cfg_wdata_i,
  input  logic [pscl_pkg::IN_DATA_W-1:0]    s_tdata_i,
  input  logic [pscl_pkg::IN_USER_W-1:0]    s_tuser_i,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output logic [pscl_pkg::OUT_DATA_W-1:0]   m_tdata_o,
  output logic [pscl_pkg::STATUS_W-1:0]     m_tuser_o,
  input  pscl_pkg::ctl_t                    ctl_i,
  output pscl_pkg::sts_t                    sts_o
);
  import pscl_pkg::*;

  localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned CB     = COUNT_BITS;
  // Table word: count, key low, key high, IPv4 flag, valid.
  localparam int unsigned KL_LSB = CB;
  localparam int unsigned KH_LSB = CB + ADDR_HALF_W;
  localparam int unsigned V4_BIT = CB + 2 * ADDR_HALF_W;
  localparam int unsigned VL_BIT = V4_BIT + 1;
  localparam int unsigned WORD_W = VL_BIT + 1;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] END_IDX  = CNT_W'(TABLE_ENTRIES);
  localparam logic [32:0] CMAX33 = (33'd1 << CB) - 33'd1;
  localparam logic [31:0] CMAX32 = CMAX33[31:0];

  logic [WORD_W-1:0] mem [TABLE_ENTRIES];
  logic [WORD_W-1:0] rd_q;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;

  logic [CNT_W-1:0]  scan_cnt_q, scan_cnt_d;
  logic              chk_vld_q;
  logic [IDX_W-1:0]  chk_idx_q;
  logic              found_q, found_d;
  logic [IDX_W-1:0]  found_idx_q, found_idx_d;
  logic [CB-1:0]     found_cnt_q, found_cnt_d;
  logic              free_q, free_d;
  logic [IDX_W-1:0]  free_idx_q, free_idx_d;

  logic [1:0]             cmd_q;
  logic                   k4_q;
  logic [ADDR_HALF_W-1:0] kh_q, kl_q;
  logic                   mapped;
  logic                   is6;
  logic [ADDR_HALF_W-1:0] in_hi, in_lo;

  logic [LIMIT_W-1:0] limit_q;
  logic [REJ_W-1:0]   rej_q, rej_d;

  logic               m_valid_q, m_valid_d;
  logic [ACTIVE_W-1:0] m_active_q;
  logic [REJ_W-1:0]   m_rej_q;
  logic [STATUS_W-1:0] m_status_q;

  logic               hit;
  logic [31:0]        cnt32, lim_eff, res_cnt32;
  logic [CB-1:0]      res_cnt, dec_cnt;
  logic [STATUS_W-1:0] res_status;

  // Key forming at load: mapped IPv6 folds to the plain IPv4 key.
  assign is6    = s_tuser_i[2];
  assign in_hi  = s_tdata_i[ADDR_HALF_W-1:0];
  assign in_lo  = s_tdata_i[IN_DATA_W-1:ADDR_HALF_W];
  assign mapped = (in_hi == '0) && (in_lo[63:32] == MAPPED_PREFIX);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= s_tuser_i[1:0];
      if (!is6 || mapped) begin
        k4_q <= 1'b1;
        kh_q <= '0;
        kl_q <= {32'd0, in_lo[31:0]};
      end else begin
        k4_q <= 1'b0;
        kh_q <= in_hi;
        kl_q <= in_lo;
      end
    end
  end

  // Table memory: one read and one write port, registered read data.
  assign rd_en   = ctl_i.scan_en && (scan_cnt_q != END_IDX);
  assign rd_addr = scan_cnt_q[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    scan_cnt_d = scan_cnt_q;
    if (ctl_i.load) begin
      scan_cnt_d = '0;
    end else if (ctl_i.clear_en || rd_en) begin
      scan_cnt_d = scan_cnt_q + CNT_W'(1);
    end
  end

  // Compare stage, one entry behind the read address.
  assign hit = chk_vld_q && rd_q[VL_BIT] && (rd_q[V4_BIT] == k4_q) &&
               (rd_q[KH_LSB +: ADDR_HALF_W] == kh_q) &&
               (rd_q[KL_LSB +: ADDR_HALF_W] == kl_q);

  always_comb begin
    found_d     = found_q;
    found_idx_d = found_idx_q;
    found_cnt_d = found_cnt_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    if (ctl_i.load) begin
      found_d = 1'b0;
      free_d  = 1'b0;
    end else begin
      if (hit && !found_q) begin
        found_d     = 1'b1;
        found_idx_d = chk_idx_q;
        found_cnt_d = rd_q[CB-1:0];
      end
      if (chk_vld_q && !rd_q[VL_BIT] && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = chk_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q   <= rd_addr;
    found_idx_q <= found_idx_d;
    found_cnt_q <= found_cnt_d;
    free_idx_q  <= free_idx_d;
  end

  // Decision and table update.
  assign cnt32   = 32'(found_cnt_q);
  assign lim_eff = ({16'd0, limit_q} < CMAX32) ? {16'd0, limit_q} : CMAX32;
  assign dec_cnt = (found_cnt_q != '0) ? (found_cnt_q - CB'(1)) : found_cnt_q;

  always_comb begin
    wr_en      = ctl_i.clear_en;
    wr_addr    = scan_cnt_q[IDX_W-1:0];
    wr_data    = '0;
    rej_d      = rej_q;
    res_status = STS_QUERY;
    res_cnt    = found_q ? found_cnt_q : '0;
    case (cmd_q)
      CMD_ACQUIRE: begin
        if (limit_q == '0) begin
          res_status = STS_UNTRACKED;
        end else if (!found_q) begin
          res_cnt = '0;
          if (free_q) begin
            wr_en      = ctl_i.commit;
            wr_addr    = free_idx_q;
            wr_data    = {1'b1, k4_q, kh_q, kl_q, CB'(1)};
            res_status = STS_GRANTED;
            res_cnt    = CB'(1);
          end else begin
            res_status = STS_TABLE_FULL;
            if (rej_q != '1) begin
              rej_d = rej_q + REJ_W'(1);
            end
          end
        end else if (cnt32 >= lim_eff) begin
          res_status = STS_OVER_LIMIT;
          if (rej_q != '1) begin
            rej_d = rej_q + REJ_W'(1);
          end
        end else begin
          wr_en      = ctl_i.commit;
          wr_addr    = found_idx_q;
          wr_data    = {1'b1, k4_q, kh_q, kl_q, found_cnt_q + CB'(1)};
          res_status = STS_GRANTED;
          res_cnt    = found_cnt_q + CB'(1);
        end
      end
      CMD_RELEASE: begin
        if (!found_q) begin
          res_status = STS_REL_IGNORE;
          res_cnt    = '0;
        end else begin
          wr_en      = ctl_i.commit;
          wr_addr    = found_idx_q;
          wr_data    = {(dec_cnt != '0), k4_q, kh_q, kl_q, dec_cnt};
          res_status = STS_RELEASED;
          res_cnt    = dec_cnt;
        end
      end
      CMD_QUERY: begin
        res_status = STS_QUERY;
      end
      default: begin
        res_status = STS_QUERY;
      end
    endcase
  end

  assign res_cnt32 = 32'(res_cnt);

  // Output register.
  always_comb begin
    m_valid_d = m_valid_q;
    if (ctl_i.commit) begin
      m_valid_d = 1'b1;
    end else if (m_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      m_status_q <= res_status;
      m_active_q <= res_cnt32[ACTIVE_W-1:0];
      m_rej_q    <= rej_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
      chk_vld_q  <= 1'b0;
      found_q    <= 1'b0;
      free_q     <= 1'b0;
      limit_q    <= '0;
      rej_q      <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      scan_cnt_q <= scan_cnt_d;
      chk_vld_q  <= rd_en;
      found_q    <= found_d;
      free_q     <= free_d;
      m_valid_q  <= m_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (ctl_i.commit) begin
        rej_q <= rej_d;
      end
    end
  end

  assign sts_o.clear_last = (scan_cnt_q == LAST_IDX);
  assign sts_o.scan_done  = (scan_cnt_q == END_IDX) && !chk_vld_q;
  assign sts_o.out_free   = !m_valid_q || m_tready_i;

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {m_rej_q, m_active_q};
  assign m_tuser_o  = m_status_q;

endmodule

// ===== hdl/per_source_connection_limiter_top.sv =====
// Per-source connection limiter: a table of up to TABLE_ENTRIES sources, each
// with an active connection count, driven by acquire, release and query
// commands on the slave stream; every command beat yields exactly one result
// beat on the master stream. An IPv4-mapped IPv6 address (::ffff:a.b.c.d)
// shares the entry of its plain IPv4 form. An acquire is refused when the
// source's count has reached max_per_source (or the largest count that
// COUNT_BITS holds) or when the table has no free entry, and each refusal
// bumps a saturating 32-bit counter; with max_per_source at zero an acquire
// is granted untracked and the table is left alone. After reset the table is
// swept clear, during which no command is taken. The table sits in a memory
// with one read and one write port, and the controller walks it one entry a
// cycle to find the source and the lowest free entry, then commits the update
// once the output register can take the result. A finished result waits in
// an output register, so the next command is accepted while it is still being
// taken. The user must see that max_per_source is written only while idle;
// the block itself does not enforce it.
module per_source_connection_limiter_top #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Limit register write.
  input  logic                            cfg_we_i,
  input  logic [pscl_pkg::LIMIT_W-1:0]    cfg_wdata_i,
  // Command stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // source_addr_high [63:0], source_addr_low [127:64]
  input  logic [pscl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // command [1:0], source_is_ipv6 [2]
  input  logic [pscl_pkg::IN_USER_W-1:0]  s_axis_tuser,
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // active_count [15:0], rejected_count [47:16]
  output logic [pscl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status [2:0]
  output logic [pscl_pkg::STATUS_W-1:0]   m_axis_tuser
);
  import pscl_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // The controller sequences the clearing sweep, the table walk and the
  // update; it owns the command side's ready.
  pscl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .ctl_o     (ctl)
  );

  // The datapath holds the table memory, the limit, the refusal counter and
  // the result register.
  pscl_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .COUNT_BITS    (COUNT_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser),
    .ctl_i       (ctl),
    .sts_o       (sts)
  );

  // No command may be taken while the table is being swept clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.clear_en |-> !s_axis_tready)
    else $error("command accepted during the clearing sweep");

  // The controller issues at most one datapath command in a cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl.clear_en, ctl.load, ctl.scan_en, ctl.commit}))
    else $error("overlapping datapath commands");

  // A committed decision always shows up as a result beat in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.commit |=> m_axis_tvalid)
    else $error("committed result not presented");

  // A result is only committed when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.commit && m_axis_tvalid) |-> m_axis_tready)
    else $error("result committed over an untaken beat");

endmodule

// ===== verif/per_source_connection_limiter_chk.sv =====
`timescale 1ns / 1ps

module per_source_connection_limiter_chk #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pscl_pkg::LIMIT_W-1:0]    cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [pscl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [pscl_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [pscl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic [pscl_pkg::STATUS_W-1:0]   m_axis_tuser,
  output int                              mismatches_o,
  output int                              outcomes_due_o,
  output int                              outcomes_seen_o,
  output int                              refusals_o,
  output int                              full_refusals_o
);

  import pscl_pkg::*;

  localparam int unsigned COUNT_MAX =
      (COUNT_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << COUNT_BITS) - 32'd1);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ACTIVE_W-1:0] active;
    logic [REJ_W-1:0]    rejected;
  } outcome_t;

  // Our own copy of the admission table.
  logic               slot_used  [TABLE_ENTRIES];
  logic               slot_v4    [TABLE_ENTRIES];
  logic [63:0]        slot_hi    [TABLE_ENTRIES];
  logic [63:0]        slot_lo    [TABLE_ENTRIES];
  int unsigned        slot_count [TABLE_ENTRIES];
  logic [REJ_W-1:0]   refused_total;
  logic [LIMIT_W-1:0] limit_q;
  outcome_t           outcome_q [$];

  int mismatch_cnt;
  int seen_cnt;
  int refusal_cnt;
  int full_cnt;

  // Applies one command to the table copy and returns the result it must give.
  function automatic outcome_t admit_outcome(input logic [1:0] cmd, input logic is6,
                                             input logic [63:0] hi, input logic [63:0] lo);
    outcome_t    res;
    logic        k4;
    logic        refuse;
    logic [63:0] kh;
    logic [63:0] kl;
    int          hit;
    int          spare;
    int          i;
    int unsigned ceiling;
    int unsigned cnt;

    // A mapped IPv6 address shares the entry of its plain IPv4 form.
    k4     = !is6 || (hi == '0 && lo[63:32] == MAPPED_PREFIX);
    kh     = k4 ? 64'd0 : hi;
    kl     = k4 ? {32'd0, lo[31:0]} : lo;
    hit    = -1;
    spare  = -1;
    refuse = 1'b0;
    cnt    = 0;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit < 0 && slot_used[i] && slot_v4[i] == k4 && slot_hi[i] == kh && slot_lo[i] == kl)
        hit = i;
      if (spare < 0 && !slot_used[i])
        spare = i;
    end

    case (cmd)
      CMD_ACQUIRE: begin
        if (limit_q == '0) begin
          res.status = STS_UNTRACKED;
          cnt = (hit >= 0) ? slot_count[hit] : 0;
        end else if (hit < 0) begin
          if (spare < 0) begin
            refuse     = 1'b1;
            res.status = STS_TABLE_FULL;
          end else begin
            slot_used[spare]  = 1'b1;
            slot_v4[spare]    = k4;
            slot_hi[spare]    = kh;
            slot_lo[spare]    = kl;
            slot_count[spare] = 1;
            res.status        = STS_GRANTED;
            cnt               = 1;
          end
        end else begin
          ceiling = (32'(limit_q) < COUNT_MAX) ? 32'(limit_q) : COUNT_MAX;
          if (slot_count[hit] >= ceiling) begin
            refuse     = 1'b1;
            res.status = STS_OVER_LIMIT;
          end else begin
            slot_count[hit]++;
            res.status = STS_GRANTED;
          end
          cnt = slot_count[hit];
        end
      end
      CMD_RELEASE: begin
        if (hit < 0) begin
          res.status = STS_REL_IGNORE;
        end else begin
          if (slot_count[hit] > 0)
            slot_count[hit]--;
          cnt = slot_count[hit];
          if (cnt == 0)
            slot_used[hit] = 1'b0;
          res.status = STS_RELEASED;
        end
      end
      default: begin
        // The spare command code behaves as a query.
        res.status = STS_QUERY;
        cnt = (hit >= 0) ? slot_count[hit] : 0;
      end
    endcase

    if (refuse && refused_total != '1)
      refused_total = refused_total + REJ_W'(1);
    res.active   = cnt[ACTIVE_W-1:0];
    res.rejected = refused_total;
    return res;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    outcome_t want;
    outcome_t got;
    int       i;

    if (!rst_ni) begin
      for (i = 0; i < TABLE_ENTRIES; i++) begin
        slot_used[i]  = 1'b0;
        slot_v4[i]    = 1'b0;
        slot_hi[i]    = '0;
        slot_lo[i]    = '0;
        slot_count[i] = 0;
      end
      refused_total = '0;
      limit_q       = '0;
      outcome_q.delete();
      mismatch_cnt  = 0;
      seen_cnt      = 0;
      refusal_cnt   = 0;
      full_cnt      = 0;
    end else begin
      if (cfg_we_i)
        limit_q = cfg_wdata_i;

      // Results first: a beat leaving now belongs to a command taken earlier.
      if (m_axis_tvalid && m_axis_tready) begin
        got.status   = m_axis_tuser;
        got.active   = m_axis_tdata[ACTIVE_W-1:0];
        got.rejected = m_axis_tdata[OUT_DATA_W-1:ACTIVE_W];
        seen_cnt++;
        if (got.status == STS_OVER_LIMIT || got.status == STS_TABLE_FULL)
          refusal_cnt++;
        if (got.status == STS_TABLE_FULL)
          full_cnt++;
        if (outcome_q.size() == 0) begin
          $display("%0t ns: result beat with nothing expected, expected none, got %h/%h",
                   $time, got.status, m_axis_tdata);
          mismatch_cnt++;
        end else begin
          want = outcome_q.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("active_count", 32'(want.active), 32'(got.active));
          check_field("rejected_count", want.rejected, got.rejected);
        end
      end

      if (s_axis_tvalid && s_axis_tready)
        outcome_q.push_back(admit_outcome(s_axis_tuser[1:0], s_axis_tuser[2],
                                          s_axis_tdata[63:0], s_axis_tdata[127:64]));
    end

    mismatches_o    <= mismatch_cnt;
    outcomes_due_o  <= outcome_q.size();
    outcomes_seen_o <= seen_cnt;
    refusals_o      <= refusal_cnt;
    full_refusals_o <= full_cnt;
  end

endmodule

// ===== verif/per_source_connection_limiter_top_tb.sv =====
`timescale 1ns / 1ps

module per_source_connection_limiter_top_tb;

  import pscl_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned COUNT_BITS    = 16;
  // The spare command code, which the block treats as a query.
  localparam logic [1:0]  CMD_SPARE     = 2'd3;
  // Sources drawn on by the random traffic: plain IPv4 first, then IPv6.
  localparam int          POOL_V4       = 40;
  localparam int          POOL_V6       = 40;
  localparam int          POOL_SIZE     = POOL_V4 + POOL_V6;
  localparam int unsigned CYCLE_LIMIT   = 4_000_000;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [LIMIT_W-1:0]    cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;

  int mismatches;
  int outcomes_due;
  int outcomes_seen;
  int refusals;
  int full_refusals;

  // When set, neither side idles: command beats follow back to back and
  // results are taken at once.
  bit          calm       = 1'b0;
  int          rdy_hold   = 0;
  int unsigned cycle_cnt  = 0;
  int          beats_sent = 0;
  int          limit_writes = 0;

  logic        pool_v6 [POOL_SIZE];
  logic [63:0] pool_hi [POOL_SIZE];
  logic [63:0] pool_lo [POOL_SIZE];

  per_source_connection_limiter_top #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .COUNT_BITS    (COUNT_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  per_source_connection_limiter_chk #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .COUNT_BITS    (COUNT_BITS)
  ) u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .mismatches_o    (mismatches),
    .outcomes_due_o  (outcomes_due),
    .outcomes_seen_o (outcomes_seen),
    .refusals_o      (refusals),
    .full_refusals_o (full_refusals)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Run stopped by the watchdog after %0d cycles.", cycle_cnt);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side back-pressure. Mostly short bursts of ready and short stalls,
  // with the odd long stall so that a finished result sits in the output
  // register while the next command is already being worked on.
  always @(posedge clk_i) begin : rdy_gen
    int r;
    if (calm) begin
      m_axis_tready <= 1'b1;
      rdy_hold      <= 0;
    end else if (rdy_hold != 0) begin
      rdy_hold <= rdy_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        m_axis_tready <= 1'b1;
        rdy_hold      <= $urandom_range(0, 30);
      end else if (r < 92) begin
        m_axis_tready <= 1'b0;
        rdy_hold      <= $urandom_range(0, 5);
      end else begin
        m_axis_tready <= 1'b0;
        rdy_hold      <= $urandom_range(40, 150);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offers one command beat after a random gap and returns once it is taken.
  // tvalid is only dropped when a gap follows, so that a back-to-back beat
  // never sees it lowered and raised in the same time step.
  task automatic send_beat(input logic [1:0] cmd, input logic is6,
                           input logic [63:0] hi, input logic [63:0] lo);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (calm || r < 60)
      gap = 0;
    else if (r < 90)
      gap = $urandom_range(1, 4);
    else
      gap = $urandom_range(20, 80);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {lo, hi};
    s_axis_tuser  <= {is6, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  // The limit may only change while the block is idle, so every result owed
  // has to have come back first. The first edge is waited out so that a beat
  // taken at the current edge is already counted as owed.
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outcomes_due != 0);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_writes++;
  endtask

  // Random traffic over the first sources of each half of the pool. A narrow
  // span drives counts up to the limit; a span wider than the table fills it.
  // One beat in ten is an arbitrary address instead.
  task automatic run_traffic(input int n, input logic [LIMIT_W-1:0] limit, input int span,
                             input int acq_pct, input int rel_pct, input bit quiet);
    int          i;
    int          r;
    int          k;
    logic [1:0]  cmd;
    logic        is6;
    logic [63:0] hi;
    logic [63:0] lo;
    write_limit(limit);
    calm = quiet;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < acq_pct)
        cmd = CMD_ACQUIRE;
      else if (r < acq_pct + rel_pct)
        cmd = CMD_RELEASE;
      else
        cmd = ($urandom_range(0, 3) == 0) ? CMD_SPARE : CMD_QUERY;

      if ($urandom_range(0, 9) == 0) begin
        is6 = 1'($urandom_range(0, 1));
        hi  = ($urandom_range(0, 3) == 0) ? 64'd0 : rand64();
        lo  = ($urandom_range(0, 3) == 0) ? {MAPPED_PREFIX, $urandom} : rand64();
      end else begin
        if ($urandom_range(0, 1) == 0)
          k = $urandom_range(0, span / 2 - 1);
        else
          k = POOL_V4 + $urandom_range(0, span / 2 - 1);
        if (pool_v6[k]) begin
          is6 = 1'b1;
          hi  = pool_hi[k];
          lo  = pool_lo[k];
        end else if ($urandom_range(0, 2) == 0) begin
          // The same IPv4 source written as a mapped IPv6 address.
          is6 = 1'b1;
          hi  = 64'd0;
          lo  = {MAPPED_PREFIX, pool_lo[k][31:0]};
        end else begin
          // Plain IPv4: the unused upper bits carry junk.
          is6 = 1'b0;
          hi  = rand64();
          lo  = {$urandom, pool_lo[k][31:0]};
        end
      end
      send_beat(cmd, is6, hi, lo);
    end
  endtask

  initial begin : stimulus
    int          k;
    logic [31:0] host_a;

    // Source pool. The IPv6 half holds two look-alikes of mapped addresses
    // that must not fold to IPv4, and the all-ones address.
    for (k = 0; k < POOL_SIZE; k++) begin
      pool_v6[k] = (k >= POOL_V4);
      pool_hi[k] = (k >= POOL_V4) ? rand64() : 64'd0;
      pool_lo[k] = (k >= POOL_V4) ? rand64() : {32'd0, $urandom};
    end
    pool_lo[0]           = {32'd0, 32'd0};
    pool_lo[1]           = {32'd0, 32'hFFFF_FFFF};
    pool_hi[POOL_V4]     = 64'd0;
    pool_lo[POOL_V4]     = {32'h0000_FFFE, $urandom};
    pool_hi[POOL_V4 + 1] = 64'd1;
    pool_lo[POOL_V4 + 1] = {MAPPED_PREFIX, $urandom};
    pool_hi[POOL_V4 + 2] = '1;
    pool_lo[POOL_V4 + 2] = '1;
    host_a               = 32'hC0A8_0001;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Limit still at its reset value of zero: acquires go through untracked,
    // a release finds nothing, and the spare code answers as a query. The
    // first beat also waits out the table sweep that follows reset.
    send_beat(CMD_ACQUIRE, 1'b0, '1, {32'hFFFF_FFFF, 32'd0});
    send_beat(CMD_RELEASE, 1'b0, 64'h0123_4567_89AB_CDEF, {32'd0, 32'hFFFF_FFFF});
    send_beat(CMD_QUERY,   1'b1, '1, '1);
    send_beat(CMD_SPARE,   1'b1, '0, '0);

    // Limit of one: the mapped form of a source hits the plain entry and is
    // refused, near misses of the mapped form get entries of their own.
    write_limit(16'd1);
    send_beat(CMD_ACQUIRE, 1'b0, rand64(), {$urandom, host_a});
    send_beat(CMD_ACQUIRE, 1'b1, '0, {MAPPED_PREFIX, host_a});
    send_beat(CMD_QUERY,   1'b0, rand64(), {$urandom, host_a});
    send_beat(CMD_ACQUIRE, 1'b1, '0, {32'h0000_FFFE, host_a});
    send_beat(CMD_ACQUIRE, 1'b1, 64'd1, {MAPPED_PREFIX, host_a});
    send_beat(CMD_ACQUIRE, 1'b1, '1, '1);
    send_beat(CMD_RELEASE, 1'b1, '0, {MAPPED_PREFIX, host_a});
    send_beat(CMD_RELEASE, 1'b0, '0, {32'd0, host_a});
    send_beat(CMD_RELEASE, 1'b1, '1, '1);

    // Widest limit, then back to zero with a live entry: the untracked
    // acquire reports the entry's count, and release still acts on it.
    write_limit(16'hFFFF);
    repeat (3) send_beat(CMD_ACQUIRE, 1'b1, '0, '0);
    write_limit(16'd0);
    send_beat(CMD_ACQUIRE, 1'b1, '0, '0);
    send_beat(CMD_RELEASE, 1'b1, '0, '0);
    send_beat(CMD_SPARE,   1'b1, '0, '0);

    // Random phases: limit, span of sources, acquire and release shares.
    run_traffic(200, 16'd1,     12,        50, 30, 1'b0);
    run_traffic(350, 16'd3,     POOL_SIZE - 8, 70, 15, 1'b0);
    run_traffic(150, 16'd0,     POOL_SIZE - 8, 40, 40, 1'b0);
    run_traffic(250, 16'hFFFF,  20,        60, 25, 1'b1);
    run_traffic(400, LIMIT_W'($urandom_range(2, 5)), POOL_SIZE - 8, 55, 30, 1'b0);
    run_traffic(300, 16'd1,     POOL_SIZE - 8, 75, 10, 1'b0);
    run_traffic(200, 16'd2,     6,         45, 45, 1'b0);

    // Drain, then allow about one command's worth of cycles for any stray
    // result beat to show up.
    s_axis_tvalid <= 1'b0;
    calm = 1'b1;
    do @(posedge clk_i); while (outcomes_due != 0);
    repeat (TABLE_ENTRIES + 8) @(posedge clk_i);

    $display("Sent %0d command beats under %0d limit settings; %0d result beats checked.",
             beats_sent, limit_writes, outcomes_seen);
    $display("%0d acquires were refused, %0d of them for want of a free entry.",
             refusals, full_refusals);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
